FILE: rtl/bsud_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsud_pkg: shared types and constants of the up/down bubble sorter
// sizes of the value store and command queue, and the command beat format
// ----------------------------------------------------------------------------
package bsud_pkg;

	localparam int MAX_ITEMS = 64;
	localparam int VAL_W     = 32;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	// register map
	localparam int          PADDR_W   = 3;
	localparam logic [0:0]  REG_DESC  = 1'b0;

	// one classified input beat, front to back
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [IDX_W-1:0]        addr;
		logic                    we;
		logic                    last;
		logic [IDX_W-1:0]        lastidx;
		logic                    trunc;
		logic                    desc;
	} cmd_t;

endpackage

FILE: rtl/bsud_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsud_ram: generic single write port ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bsud_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/bsud_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsud_cmdq: short command queue between front and back
// register based fifo of classified beats
// ----------------------------------------------------------------------------
module bsud_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bsud_pkg::cmd_t cmd_in,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output bsud_pkg::cmd_t cmd_out
);
	import bsud_pkg::*;

	cmd_t              buf_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign valid   = (cnt_q != '0);
	assign cmd_out = buf_q[rd_ptr_q];
	assign do_push = push & ~full;
	assign do_pop  = pop & valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
		end
	end

endmodule

FILE: rtl/bsud_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsud_front: input classifier
// counts the run, decides store or drop, tags end of run beats
// ----------------------------------------------------------------------------
module bsud_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic signed [bsud_pkg::VAL_W-1:0] value_in,
	input  logic                            last_in,
	input  logic                            desc,
	output bsud_pkg::cmd_t                  cmd
);
	import bsud_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             store;

	// room left in the store
	assign store = (count_q < CNT_W'(MAX_ITEMS));

	always_comb begin
		cmd.value   = value_in;
		cmd.addr    = count_q[IDX_W-1:0];
		cmd.we      = store;
		cmd.last    = last_in;
		cmd.lastidx = store ? count_q[IDX_W-1:0] : IDX_W'(count_q - 1'b1);
		cmd.trunc   = ovf_q | ~store;
		cmd.desc    = desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (last_in) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (store) begin
				count_q <= count_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/bsud_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsud_back: store, sort and emit engine
// loads beats into the ram, runs bubble passes, drains through a result fifo
// ----------------------------------------------------------------------------
module bsud_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  bsud_pkg::cmd_t                    q_cmd,
	output logic                              q_pop,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [bsud_pkg::VAL_W-1:0] value_out,
	output logic                              last_out,
	output logic                              truncated
);
	import bsud_pkg::*;

	typedef enum logic [2:0] {
		S_LOAD,
		S_RD0,
		S_CAR,
		S_PASS,
		S_END,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    last;
		logic                    trunc;
	} res_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        lastidx_q;
	logic                    trunc_q;
	logic                    desc_q;
	logic [IDX_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] carry_q;
	logic                    swapped_q;
	logic [IDX_W-1:0]        emit_k_q;
	logic                    issued_all_q;
	logic                    pend_q;
	logic                    pend_last_q;
	res_t                    obuf_q [2];
	logic                    owr_q;
	logic                    ord_q;
	logic [1:0]              occ_q;

	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic signed [VAL_W-1:0] ram_wdata;
	logic                    ram_re;
	logic [IDX_W-1:0]        ram_raddr;
	logic signed [VAL_W-1:0] ram_rdata;
	logic                    ooo;
	logic                    pop_fire;
	logic                    issue;

	bsud_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign q_pop    = (state_q == S_LOAD) & q_valid;
	assign pop_fire = pop & ~empty;
	assign empty    = (occ_q == 2'd0);
	assign value_out = obuf_q[ord_q].value;
	assign last_out  = obuf_q[ord_q].last;
	assign truncated = obuf_q[ord_q].trunc;

	// incoming element is out of order against the one bubbling up
	assign ooo = desc_q ? (ram_rdata > carry_q) : (carry_q > ram_rdata);

	// a read lands in the cycle after it is issued, so count it against fifo room
	assign issue = (state_q == S_EMIT) & ~issued_all_q &
		((3'(occ_q) + 3'(pend_q)) <= (3'd1 + 3'(pop_fire)));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = q_cmd.addr;
		ram_wdata = q_cmd.value;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_LOAD: begin
				ram_we = q_pop & q_cmd.we;
			end
			S_RD0: begin
				ram_re = 1'b1;
			end
			S_CAR: begin
				ram_re    = 1'b1;
				ram_raddr = IDX_W'(1);
			end
			S_PASS: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q - 1'b1;
				ram_wdata = ooo ? ram_rdata : carry_q;
				ram_re    = (pos_q != lastidx_q);
				ram_raddr = pos_q + 1'b1;
			end
			S_END: begin
				ram_we    = 1'b1;
				ram_waddr = lastidx_q;
				ram_wdata = carry_q;
			end
			S_EMIT: begin
				ram_re    = issue;
				ram_raddr = emit_k_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// result fifo storage
	always_ff @(posedge clk) begin
		if (pend_q) begin
			obuf_q[owr_q] <= '{value: ram_rdata, last: pend_last_q, trunc: trunc_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			lastidx_q    <= '0;
			trunc_q      <= 1'b0;
			desc_q       <= 1'b0;
			pos_q        <= '0;
			carry_q      <= '0;
			swapped_q    <= 1'b0;
			emit_k_q     <= '0;
			issued_all_q <= 1'b0;
			pend_q       <= 1'b0;
			pend_last_q  <= 1'b0;
			owr_q        <= 1'b0;
			ord_q        <= 1'b0;
			occ_q        <= 2'd0;
		end else begin
			pend_q      <= issue;
			pend_last_q <= issue & (emit_k_q == lastidx_q);
			if (pend_q) begin
				owr_q <= ~owr_q;
			end
			if (pop_fire) begin
				ord_q <= ~ord_q;
			end
			occ_q <= occ_q + 2'(pend_q) - 2'(pop_fire);

			unique case (state_q)
				S_LOAD: begin
					if (q_pop && q_cmd.last) begin
						lastidx_q    <= q_cmd.lastidx;
						trunc_q      <= q_cmd.trunc;
						desc_q       <= q_cmd.desc;
						emit_k_q     <= '0;
						issued_all_q <= 1'b0;
						state_q      <= (q_cmd.lastidx == '0) ? S_EMIT : S_RD0;
					end
				end
				S_RD0: begin
					swapped_q <= 1'b0;
					state_q   <= S_CAR;
				end
				S_CAR: begin
					carry_q <= ram_rdata;
					pos_q   <= IDX_W'(1);
					state_q <= S_PASS;
				end
				S_PASS: begin
					if (!ooo) begin
						carry_q <= ram_rdata;
					end
					swapped_q <= swapped_q | ooo;
					if (pos_q == lastidx_q) begin
						state_q <= S_END;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				S_END: begin
					state_q <= swapped_q ? S_RD0 : S_EMIT;
				end
				S_EMIT: begin
					if (issue) begin
						emit_k_q <= emit_k_q + 1'b1;
						if (emit_k_q == lastidx_q) begin
							issued_all_q <= 1'b1;
						end
					end
					if (issued_all_q && !pend_q) begin
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 2'd2)
		else $error("result fifo occupancy out of range");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (occ_q < 2'd2) || pop_fire)
		else $error("result fifo overrun");

	a_pass_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PASS) |-> (pos_q != '0) && (pos_q <= lastidx_q))
		else $error("pass position out of range");

	a_load_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> !pend_q && !issue)
		else $error("read in flight while loading");

	a_sorted_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_END) && !swapped_q |=> (state_q == S_EMIT))
		else $error("clean pass did not lead to emit");
`endif

endmodule

FILE: rtl/bubble_sort_up_down_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bubble_sort_up_down_top: run collector and bubble sorter
// collects signed values, sorts them up or down, emits the sorted run
// ----------------------------------------------------------------------------
// usage
//  - input channel: push with value_in/last_in while full is low; one beat a
//    cycle is taken. a beat with last_in high closes the run
//  - up to 64 values per run are kept; further beats are dropped and every
//    result of that run carries truncated
//  - result channel: while empty is low, value_out/last_out/truncated show
//    the oldest result; pop takes it. last_out marks the end of the run
//  - config: one apb register at address 0, bit 0 = descending; pready is
//    always high, write only while the block is idle
//  - timing: loading takes one beat a cycle while the queue holds beats. after the
//    closing beat each bubble pass walks the n values through the single store
//    ram (one read and one write port); passes repeat until one makes no swap,
//    at most n passes. emit then streams one result a cycle through the
//    registered ram read while the result fifo has room
//  - a pop stall holds the two entry result fifo and the engine's emit; the command queue
//    between classifier and engine keeps taking beats until it fills
//  - reset clears the run count, the queue, the result fifo and the order
//    bit; the store ram itself is not cleared
// ----------------------------------------------------------------------------
module bubble_sort_up_down_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input queue side
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [bsud_pkg::VAL_W-1:0]     value_in,
	input  logic                                  last_in,
	// result queue side
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [bsud_pkg::VAL_W-1:0]     value_out,
	output logic                                  last_out,
	output logic                                  truncated,
	// apb config port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [bsud_pkg::PADDR_W-1:0]          paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);
	import bsud_pkg::*;

	logic desc_q;
	logic cfg_sel;
	logic accept;
	logic q_valid;
	logic q_pop;
	cmd_t f_cmd;
	cmd_t q_cmd;

	// register index is the word address
	assign cfg_sel = (paddr[PADDR_W-1] == REG_DESC);
	assign pready  = 1'b1;
	assign prdata  = cfg_sel ? {31'b0, desc_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			desc_q <= pwdata[0];
		end
	end

	// an input beat is taken whenever the queue has room
	assign accept = push & ~full;

	bsud_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.value_in(value_in),
		.last_in (last_in),
		.desc    (desc_q),
		.cmd     (f_cmd)
	);

	// decouples the classifier from the sort engine
	bsud_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (f_cmd),
		.full   (full),
		.pop    (q_pop),
		.valid  (q_valid),
		.cmd_out(q_cmd)
	);

	// store, sort passes and result drain
	bsud_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.value_out(value_out),
		.last_out (last_out),
		.truncated(truncated)
	);

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the up/down bubble sorter
// drives runs of signed values through the input queue, keeps its own sorted
// copy of every run and checks each popped beat against it; directed corner
// runs come first, then random runs of many lengths, from one up to past the store depth
// ----------------------------------------------------------------------------
module testbench;

	import bsud_pkg::*;

	localparam int                 CLK_HALF    = 4;
	localparam int                 RESET_CYC   = 9;
	localparam int                 RAND_ITEMS  = 400;
	localparam int                 SETTLE_CYC  = 40;
	localparam int                 CYCLE_LIMIT = 600000;
	localparam logic [PADDR_W-1:0] ADDR_DESC   = PADDR_W'(4 * REG_DESC);
	// first address past the register list, writes there must be ignored
	localparam logic [PADDR_W-1:0] ADDR_SPARE  = PADDR_W'(4);
	localparam int                 N_DIRECTED  = 21;

	// one popped beat as the sorter should produce it
	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    last;
		logic                    trunc;
	} sorted_beat_t;

	// one row of the directed table
	typedef struct {
		logic                    set_cfg;	// change the order bit before this beat
		logic                    cfg_desc;
		logic signed [VAL_W-1:0] value;
		logic                    last;
		logic                    typed;		// single-value run, result typed in below
		logic signed [VAL_W-1:0] exp_value;
	} stim_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    push;
	logic                    full;
	logic signed [VAL_W-1:0] value_in;
	logic                    last_in;
	logic                    empty;
	logic                    pop;
	logic signed [VAL_W-1:0] value_out;
	logic                    last_out;
	logic                    truncated;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [PADDR_W-1:0]      paddr;
	logic [31:0]             pwdata;
	logic [31:0]             prdata;
	logic                    pready;

	// sorter model state: values of the open run, drop flag, order bit
	logic signed [VAL_W-1:0] run_values [$];
	logic                    run_dropped;
	logic                    order_desc;

	// beats still owed by the block, oldest first
	sorted_beat_t            sorted_results [$];

	stim_row_t               directed_rows [N_DIRECTED];
	int                      mismatches;
	int                      cycle_count;
	int                      burst_left;
	logic [11:0]             stall_phase;

	bubble_sort_up_down_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.value_in  (value_in),
		.last_in   (last_in),
		.empty     (empty),
		.pop       (pop),
		.value_out (value_out),
		.last_out  (last_out),
		.truncated (truncated),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// one line per mismatch, counted for the final verdict
	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// append one beat to the list of beats owed by the block
	task automatic owe_beat(input sorted_beat_t b);
		sorted_results.insert(sorted_results.size(), b);
	endtask

	// model of the block for one accepted beat: store or drop, and on the
	// closing beat sort the run stably and queue one beat per stored value
	task automatic sorter_accept(input logic signed [VAL_W-1:0] v, input logic closes);
		logic signed [VAL_W-1:0] hold;
		logic                    swapped;
		logic                    wrong_way;
		int                      n;
		sorted_beat_t            beat;
		if (run_values.size() < MAX_ITEMS)
			run_values.insert(run_values.size(), v);
		else
			run_dropped = 1'b1;
		if (closes) begin
			n = run_values.size();
			// repeat adjacent passes until one is clean, equal pairs never move
			do begin
				swapped = 1'b0;
				for (int i = 0; i + 1 < n; i++) begin
					wrong_way = order_desc ? (run_values[i+1] > run_values[i])
					                       : (run_values[i] > run_values[i+1]);
					if (wrong_way) begin
						hold            = run_values[i];
						run_values[i]   = run_values[i+1];
						run_values[i+1] = hold;
						swapped         = 1'b1;
					end
				end
			end while (swapped);
			for (int k = 0; k < n; k++) begin
				beat.value = run_values[k];
				beat.last  = (k == n - 1);
				beat.trunc = run_dropped;
				owe_beat(beat);
			end
			run_values.delete();
			run_dropped = 1'b0;
		end
	endtask

	// one input beat; the sender runs in bursts with idle gaps in between,
	// and push stays high from one beat of a burst to the next
	task automatic send_value(input logic signed [VAL_W-1:0] v, input logic closes);
		if (burst_left == 0) begin
			// mostly short bursts, now and then a long stretch with no idling
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 12);
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		burst_left--;
		push     <= 1'b1;
		value_in <= v;
		last_in  <= closes;
		do @(posedge clk); while (full);
	endtask

	// let the block empty out: every owed beat popped, then a short settle
	task automatic drain_results();
		push <= 1'b0;
		while (sorted_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// setup, access, then back to idle before the next transfer
	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// change the sort order on an idle block; junk in the upper bits and a
	// write past the register list must both leave the order bit alone
	task automatic set_order(input logic d);
		logic [31:0] rdata;
		drain_results();
		apb_write(ADDR_DESC, {31'($urandom_range(0, 32'h7fff_ffff)), d});
		apb_write(ADDR_SPARE, $urandom);
		order_desc = d;
		apb_read(ADDR_DESC, rdata);
		if (rdata[0] !== d)
			report_mismatch("descending readback", rdata[0], d);
	endtask

	// result side: check every popped beat, then pick the next pop value
	// from a stall pattern that cycles through four modes
	always @(posedge clk) begin : result_side
		sorted_beat_t want;
		if (!arst_n) begin
			pop         <= 1'b0;
			stall_phase <= '0;
		end else begin
			if (pop && !empty) begin
				if (sorted_results.size() == 0) begin
					report_mismatch("beat with nothing owed, value_out", value_out, 0);
				end else begin
					want = sorted_results.pop_front();
					if (value_out !== want.value)
						report_mismatch("value_out", value_out, want.value);
					if (last_out !== want.last)
						report_mismatch("last_out", last_out, want.last);
					if (truncated !== want.trunc)
						report_mismatch("truncated", truncated, want.trunc);
				end
			end
			stall_phase <= stall_phase + 1'b1;
			case (stall_phase[9:8])
				2'd0: pop <= 1'b1;                          // no stalls at all
				2'd1: pop <= (stall_phase[1:0] == 2'd0);    // one pop in four
				2'd2: pop <= 1'($urandom_range(0, 1));      // coin flip
				default: pop <= stall_phase[4];             // long on/off stretches
			endcase
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		logic signed [VAL_W-1:0] v;
		logic signed [VAL_W-1:0] base;
		int                      run_len;
		int                      fill_mode;
		int                      step;
		int                      sent;
		sorted_beat_t            typed_beat;

		// every input known from time zero
		arst_n      = 1'b0;
		push        = 1'b0;
		value_in    = '0;
		last_in     = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		burst_left  = 0;
		run_dropped = 1'b0;
		order_desc  = 1'b0;

		// directed runs: extremes as single-value runs with the answer typed
		// in, then short mixed runs in both orders with ties and extremes
		directed_rows = '{
			'{1'b1, 1'b0, 32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000},
			'{1'b0, 1'b0, 32'sh7fff_ffff, 1'b1, 1'b1, 32'sh7fff_ffff},
			'{1'b0, 1'b0, 32'sh0000_0000, 1'b1, 1'b1, 32'sh0000_0000},
			'{1'b0, 1'b0, -32'sd1,        1'b1, 1'b1, -32'sd1},
			'{1'b0, 1'b0, 32'sd5,         1'b0, 1'b0, '0},
			'{1'b0, 1'b0, -32'sd1,        1'b0, 1'b0, '0},
			'{1'b0, 1'b0, 32'sh7fff_ffff, 1'b0, 1'b0, '0},
			'{1'b0, 1'b0, 32'sh8000_0000, 1'b0, 1'b0, '0},
			'{1'b0, 1'b0, -32'sd1,        1'b1, 1'b0, '0},
			'{1'b1, 1'b1, -32'sd7,        1'b1, 1'b1, -32'sd7},
			'{1'b0, 1'b0, 32'sd3,         1'b0, 1'b0, '0},
			'{1'b0, 1'b0, 32'sd3,         1'b0, 1'b0, '0},
			'{1'b0, 1'b0, 32'sh8000_0000, 1'b0, 1'b0, '0},
			'{1'b0, 1'b0, 32'sh7fff_ffff, 1'b0, 1'b0, '0},
			'{1'b0, 1'b0, 32'sd0,         1'b0, 1'b0, '0},
			'{1'b0, 1'b0, 32'sd1,         1'b1, 1'b0, '0},
			'{1'b0, 1'b0, -32'sd1,        1'b0, 1'b0, '0},
			'{1'b0, 1'b0, 32'sd1,         1'b1, 1'b0, '0},
			'{1'b1, 1'b0, 32'sh5555_5555, 1'b0, 1'b0, '0},
			'{1'b0, 1'b0, 32'shaaaa_aaaa, 1'b0, 1'b0, '0},
			'{1'b0, 1'b0, 32'sd1,         1'b1, 1'b0, '0}
		};

		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].set_cfg)
				set_order(directed_rows[r].cfg_desc);
			send_value(directed_rows[r].value, directed_rows[r].last);
			if (directed_rows[r].typed) begin
				typed_beat.value = directed_rows[r].exp_value;
				typed_beat.last  = 1'b1;
				typed_beat.trunc = 1'b0;
				owe_beat(typed_beat);
			end else begin
				sorter_accept(directed_rows[r].value, directed_rows[r].last);
			end
		end

		// random runs: mostly short, some near the store depth, a few past it
		sent = 0;
		while (sent < RAND_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				set_order(1'($urandom_range(0, 1)));
			case ($urandom_range(0, 19))
				0, 1:    run_len = $urandom_range(MAX_ITEMS - 3, MAX_ITEMS);
				2:       run_len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
				3, 4, 5: run_len = $urandom_range(13, 40);
				default: run_len = $urandom_range(1, 12);
			endcase
			fill_mode = $urandom_range(0, 4);
			base      = $urandom;
			step      = $urandom_range(1, 1000);
			for (int k = 0; k < run_len; k++) begin
				case (fill_mode)
					0: v = $urandom;
					1: v = $signed($urandom_range(0, 6)) - 32'sd3;    // many ties
					2: case ($urandom_range(0, 4))
						0: v = 32'sh8000_0000;
						1: v = 32'sh7fff_ffff;
						2: v = 32'sd0;
						3: v = -32'sd1;
						default: v = 32'sd1;
					endcase
					3: v = (base >>> 2) + k * step;                     // already rising
					default: v = (base >>> 2) - k * step;               // already falling
				endcase
				send_value(v, k == run_len - 1);
				sorter_accept(v, k == run_len - 1);
			end
			sent += run_len;
		end

		drain_results();
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
